@@ sv/rripsd_pkg.sv @@
// Shared constants, types and helpers of the RRIP replacement block.
package rripsd_pkg;

    localparam int NUM_SETS     = 2048;
    localparam int SET_W        = $clog2(NUM_SETS);
    localparam int NUM_WAYS     = 16;
    localparam int WAY_W        = $clog2(NUM_WAYS);
    localparam int LEADER_SETS  = 32;
    localparam int HIST_DEPTH   = 4;
    localparam int HPTR_W       = $clog2(HIST_DEPTH);
    localparam int ADDR_W       = 48;
    localparam int RRPV_W       = 2;
    localparam int REUSE_W      = 2;
    localparam int SEL_W        = 10;
    localparam int LFSR_W       = 16;
    localparam int ODDS_W       = 4;

    localparam logic [SEL_W-1:0]   SEL_MAX    = {SEL_W{1'b1}};
    localparam logic [SEL_W-1:0]   SEL_MID    = {1'b1, {(SEL_W-1){1'b0}}};
    localparam logic [LFSR_W-1:0]  LFSR_SEED  = 16'hACE1;
    localparam logic [ODDS_W-1:0]  ODDS_RESET = 4'd5;

    localparam logic [RRPV_W-1:0]  RRPV_NEAR    = 2'd0;
    localparam logic [RRPV_W-1:0]  RRPV_LONG    = 2'd2;
    localparam logic [RRPV_W-1:0]  RRPV_DISTANT = 2'd3;
    localparam logic [REUSE_W-1:0] REUSE_FILL   = 2'd1;
    localparam logic [REUSE_W-1:0] REUSE_STRONG = 2'd2;
    localparam logic [REUSE_W-1:0] REUSE_MAX    = 2'd3;

    typedef enum logic {
        REQ_VICTIM = 1'b0,
        REQ_UPDATE = 1'b1
    } req_kind_t;

    typedef struct packed {
        req_kind_t            req_type;
        logic [SET_W-1:0]     set_index;
        logic [WAY_W-1:0]     way_index;
        logic [NUM_WAYS-1:0]  valid_mask;
        logic [ADDR_W-1:0]    phys_addr;
        logic                 was_hit;
    } req_t;

    // One row per set: reuse counters and RRPVs of every way.
    typedef struct packed {
        logic [NUM_WAYS-1:0][REUSE_W-1:0] reuse;
        logic [NUM_WAYS-1:0][RRPV_W-1:0]  rrpv;
    } meta_row_t;

    // One row per set: history pointer and recorded addresses.
    typedef struct packed {
        logic [HPTR_W-1:0]                 ptr;
        logic [HIST_DEPTH-1:0][ADDR_W-1:0] addr;
    } hist_row_t;

    localparam int META_W = $bits(meta_row_t);
    localparam int HIST_W = $bits(hist_row_t);

    localparam meta_row_t META_RESET = '{
        reuse: {NUM_WAYS{REUSE_FILL}},
        rrpv:  {NUM_WAYS{RRPV_DISTANT}}
    };
    localparam hist_row_t HIST_RESET = '0;

    // Result of one row update, plus the new global policy state.
    typedef struct packed {
        logic               meta_we;
        logic               hist_we;
        logic [WAY_W-1:0]   victim_way;
        logic               streaming;
        logic [SEL_W-1:0]   psel_next;
        logic [LFSR_W-1:0]  lfsr_next;
    } step_t;

    // Fibonacci LFSR, taps 16,14,13,11.
    function automatic logic [LFSR_W-1:0] lfsr_advance(input logic [LFSR_W-1:0] v);
        logic b;
        b = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {b, v[LFSR_W-1:1]};
    endfunction

endpackage

@@ sv/rripsd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rripsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/rripsd_step.sv @@
// Row update: victim choice, aging, stream detection and insertion policy.
module rripsd_step
    import rripsd_pkg::*;
(
    input  req_t               req,
    input  meta_row_t          meta_q,
    input  hist_row_t          hist_q,
    input  logic [SEL_W-1:0]   psel,
    input  logic [LFSR_W-1:0]  lfsr,
    input  logic [ODDS_W-1:0]  odds,
    output meta_row_t          meta_d,
    output hist_row_t          hist_d,
    output step_t              step
);

    logic                              inv_found;
    logic [WAY_W-1:0]                  inv_way;
    logic [3:0]                        any_val;
    logic [RRPV_W-1:0]                 max_rrpv;
    logic [RRPV_W-1:0]                 age;
    logic [NUM_WAYS-1:0][RRPV_W-1:0]   rrpv_aged;
    logic [WAY_W-1:0]                  aged_pick;
    logic [HIST_DEPTH-1:0][ADDR_W-1:0] hist_new;
    logic [ADDR_W:0]                   diff [HIST_DEPTH];
    logic                              last_slot;
    logic                              stride_eq;
    logic                              streaming;
    logic                              srrip_leader;
    logic                              brrip_leader;
    logic                              use_srrip;
    logic [LFSR_W-1:0]                 lfsr_adv;
    logic [LFSR_W-1:0]                 odds_mask;
    logic                              brrip_near;
    logic [RRPV_W-1:0]                 ins_rrpv;
    logic [REUSE_W-1:0]                reuse_old;

    // Victim search: first invalid way, else first way at the top after aging.
    always_comb begin
        inv_found = 1'b0;
        inv_way   = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (!req.valid_mask[w]) begin
                inv_found = 1'b1;
                inv_way   = WAY_W'(w);
            end
        end
        any_val = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            any_val[meta_q.rrpv[w]] = 1'b1;
        end
        priority if (any_val[3]) max_rrpv = 2'd3;
        else if (any_val[2])     max_rrpv = 2'd2;
        else if (any_val[1])     max_rrpv = 2'd1;
        else                     max_rrpv = 2'd0;
        age = RRPV_DISTANT - max_rrpv;
        for (int w = 0; w < NUM_WAYS; w++) begin
            rrpv_aged[w] = meta_q.rrpv[w] + age;
        end
        aged_pick = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (rrpv_aged[w] == RRPV_DISTANT) begin
                aged_pick = WAY_W'(w);
            end
        end
    end

    // Stride check over the history with the new address in place.
    always_comb begin
        hist_new = hist_q.addr;
        hist_new[hist_q.ptr] = req.phys_addr;
        last_slot = (hist_q.ptr == HPTR_W'(HIST_DEPTH - 1));
        diff[0] = '0;
        for (int i = 1; i < HIST_DEPTH; i++) begin
            diff[i] = {1'b0, hist_new[i]} - {1'b0, hist_new[i-1]};
        end
        stride_eq = 1'b1;
        for (int i = 2; i < HIST_DEPTH; i++) begin
            if (diff[i] != diff[1]) begin
                stride_eq = 1'b0;
            end
        end
        streaming = last_slot && stride_eq;
    end

    // Insertion policy and selector.
    always_comb begin
        srrip_leader = (req.set_index < SET_W'(LEADER_SETS));
        brrip_leader = !srrip_leader && (req.set_index >= SET_W'(NUM_SETS - LEADER_SETS));
        use_srrip    = srrip_leader || (!brrip_leader && psel >= SEL_MID);
        lfsr_adv     = lfsr_advance(lfsr);
        odds_mask    = ~({LFSR_W{1'b1}} << odds);
        brrip_near   = ((lfsr_adv & odds_mask) == '0);
        reuse_old    = meta_q.reuse[req.way_index];

        if (use_srrip || brrip_near) ins_rrpv = RRPV_LONG;
        else                         ins_rrpv = RRPV_DISTANT;
        if (reuse_old >= REUSE_STRONG) ins_rrpv = RRPV_NEAR;
        if (streaming)                 ins_rrpv = RRPV_DISTANT;
    end

    always_comb begin
        meta_d = meta_q;
        hist_d.addr = hist_new;
        hist_d.ptr  = last_slot ? '0 : hist_q.ptr + HPTR_W'(1);
        step.meta_we    = 1'b0;
        step.hist_we    = 1'b0;
        step.victim_way = '0;
        step.streaming  = 1'b0;
        step.psel_next  = psel;
        step.lfsr_next  = lfsr;

        unique case (req.req_type)
            REQ_VICTIM: begin
                if (inv_found) begin
                    step.victim_way = inv_way;
                end else begin
                    step.victim_way = aged_pick;
                    step.meta_we    = 1'b1;
                    meta_d.rrpv     = rrpv_aged;
                end
            end
            REQ_UPDATE: begin
                step.hist_we   = 1'b1;
                step.meta_we   = 1'b1;
                step.streaming = streaming;
                if (req.was_hit) begin
                    meta_d.rrpv[req.way_index] = RRPV_NEAR;
                    if (reuse_old != REUSE_MAX) begin
                        meta_d.reuse[req.way_index] = reuse_old + REUSE_W'(1);
                    end
                    if (srrip_leader && psel != SEL_MAX) begin
                        step.psel_next = psel + SEL_W'(1);
                    end else if (brrip_leader && psel != '0) begin
                        step.psel_next = psel - SEL_W'(1);
                    end
                end else begin
                    meta_d.rrpv[req.way_index]  = ins_rrpv;
                    meta_d.reuse[req.way_index] = REUSE_FILL;
                    // advance the random source only on the bimodal branch
                    if (!use_srrip) begin
                        step.lfsr_next = lfsr_adv;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

@@ sv/rrip_replacement_with_stream_detect.sv @@
// Top level: DRRIP replacement state with per-set stream detection.
//
//  channel   ports                                    direction  handshake
//  request   s_req_type .. s_was_hit                  in         s_valid / s_ready
//  result    m_victim_way, m_streaming_seen           out        m_valid / m_ready
//  config    cfg_wdata (brrip_odds_log2)              in         cfg_we, no wait
//
//  For each beat, the accept cycle reads the set's rows from the
//  block-state RAM and the history RAM; in ST_BUSY the block then modifies
//  them, writes them back and loads the result register.
//  After reset a clearing pass over all 2048 sets (one set a cycle) runs before
//  s_ready rises; configuration writes are taken during it.
//  A full result register holds the block in its write-back cycle until m_ready.
module rrip_replacement_with_stream_detect
    import rripsd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [ODDS_W-1:0]  cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [SET_W-1:0]   s_set_index,
    input  logic [WAY_W-1:0]   s_way_index,
    input  logic [NUM_WAYS-1:0] s_valid_mask,
    input  logic [ADDR_W-1:0]  s_phys_addr,
    input  logic               s_was_hit,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [WAY_W-1:0]   m_victim_way,
    output logic               m_streaming_seen
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BUSY
    } state_t;

    state_t             state_reg;
    logic [SET_W-1:0]   clr_cnt_reg;
    req_t               req_reg;
    logic [ODDS_W-1:0]  odds_reg;
    logic [SEL_W-1:0]   psel_reg;
    logic [LFSR_W-1:0]  lfsr_reg;
    logic               m_valid_reg;
    logic [WAY_W-1:0]   victim_reg;
    logic               stream_reg;

    logic               accept;
    logic               commit;
    logic               clearing;
    meta_row_t          meta_q;
    meta_row_t          meta_d;
    hist_row_t          hist_q;
    hist_row_t          hist_d;
    step_t              step;
    logic               meta_we;
    logic               hist_we;
    logic [SET_W-1:0]   waddr;
    logic [META_W-1:0]  meta_wdata;
    logic [HIST_W-1:0]  hist_wdata;
    logic [META_W-1:0]  meta_rdata;
    logic [HIST_W-1:0]  hist_rdata;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign clearing = (state_reg == ST_CLEAR);
    assign commit   = (state_reg == ST_BUSY) && (!m_valid_reg || m_ready);

    assign meta_we    = clearing || (commit && step.meta_we);
    assign hist_we    = clearing || (commit && step.hist_we);
    assign waddr      = clearing ? clr_cnt_reg : req_reg.set_index;
    assign meta_wdata = clearing ? META_RESET : meta_d;
    assign hist_wdata = clearing ? HIST_RESET : hist_d;
    assign meta_q     = meta_row_t'(meta_rdata);
    assign hist_q     = hist_row_t'(hist_rdata);

    rripsd_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_SETS)
    ) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (waddr),
        .wdata (meta_wdata),
        .re    (accept),
        .raddr (s_set_index),
        .rdata (meta_rdata)
    );

    rripsd_ram #(
        .WIDTH (HIST_W),
        .DEPTH (NUM_SETS)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (waddr),
        .wdata (hist_wdata),
        .re    (accept),
        .raddr (s_set_index),
        .rdata (hist_rdata)
    );

    rripsd_step u_step (
        .req    (req_reg),
        .meta_q (meta_q),
        .hist_q (hist_q),
        .psel   (psel_reg),
        .lfsr   (lfsr_reg),
        .odds   (odds_reg),
        .meta_d (meta_d),
        .hist_d (hist_d),
        .step   (step)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            odds_reg    <= ODDS_RESET;
            psel_reg    <= SEL_MID;
            lfsr_reg    <= LFSR_SEED;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                odds_reg <= cfg_wdata;
            end
            // drop the result once taken, unless a new one replaces it
            if (m_valid_reg && m_ready && !commit) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
                    if (clr_cnt_reg == SET_W'(NUM_SETS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        req_reg.req_type   <= req_kind_t'(s_req_type);
                        req_reg.set_index  <= s_set_index;
                        req_reg.way_index  <= s_way_index;
                        req_reg.valid_mask <= s_valid_mask;
                        req_reg.phys_addr  <= s_phys_addr;
                        req_reg.was_hit    <= s_was_hit;
                        state_reg          <= ST_BUSY;
                    end
                end
                ST_BUSY: begin
                    // hold until the result register frees up
                    if (commit) begin
                        psel_reg    <= step.psel_next;
                        lfsr_reg    <= step.lfsr_next;
                        victim_reg  <= step.victim_way;
                        stream_reg  <= step.streaming;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_CLEAR;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_victim_way     = victim_reg;
    assign m_streaming_seen = stream_reg;

    // The random source must never lock up at zero.
    a_lfsr_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        lfsr_reg != '0)
        else $error("LFSR reached the all-zero state");

    // An accepted beat blocks further input for its write-back cycle.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready && (state_reg == ST_BUSY))
        else $error("second beat accepted during read-modify-write");

    // A write-back always leaves a result waiting.
    a_commit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_valid_reg && s_ready)
        else $error("write-back without a result");

    // No result appears while the clearing pass runs.
    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !m_valid_reg && !s_ready)
        else $error("activity during clearing pass");

endmodule
